// ----- design/assert_macros.svh -----
// Assertion macros shared by the converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- design/ffc_pkg.sv -----
`timescale 1ns / 1ps
package ffc_pkg;
  typedef enum logic [1:0] {
    MODE_BF16_TO_F32 = 2'd0,
    MODE_F16_TO_F32  = 2'd1,
    MODE_F32_TO_BF16 = 2'd2,
    MODE_F32_TO_F16  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [31:0] operand;
    logic        last_element;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        end_of_run;
  } out_word_t;

  // Conversion from binary16 to binary32.
  function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  lz;
    logic [10:0] mn;
    logic [7:0]  ex;
    logic [31:0] r;
    e  = h[14:10];
    m  = h[9:0];
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) lz = 4'(9 - i);
    end
    mn = {1'b0, m} << (lz + 4'd1);
    ex = 8'd112 - 8'(lz);
    if (e == 5'd0) begin
      if (m == 10'd0) r = {h[15], 31'd0};
      else r = {h[15], ex, mn[9:0], 13'd0};
    end else if (e == 5'd31) begin
      r = {h[15], 8'hff, m, 13'd0};
    end else begin
      r = {h[15], 8'(e) + 8'd112, m, 13'd0};
    end
    return r;
  endfunction

  // Rounding conversion from binary32 to bfloat16.
  function automatic logic [15:0] f32_to_bf16(input logic [31:0] x);
    logic [31:0] s;
    s = x + 32'h7fff + {31'd0, x[16]};
    return s[31:16];
  endfunction

  // Rounding conversion from binary32 to binary16.
  function automatic logic [15:0] f32_to_f16(input logic [31:0] x);
    logic [7:0]  ef;
    logic [22:0] m;
    logic [23:0] mf;
    logic [4:0]  sh;
    logic [23:0] hm;
    logic [23:0] rem;
    logic [23:0] mid;
    logic        up;
    logic [10:0] hn;
    logic [15:0] r;
    ef  = x[30:23];
    m   = x[22:0];
    mf  = {1'b1, m};
    sh  = 5'd0;
    hm  = 24'd0;
    rem = 24'd0;
    mid = 24'd0;
    up  = 1'b0;
    hn  = 11'd0;
    if (ef == 8'hff) begin
      if (m == 23'd0) r = {x[31], 15'h7c00};
      else if (m[22:13] == 10'd0) r = {x[31], 5'h1f, 10'd1};
      else r = {x[31], 5'h1f, m[22:13]};
    end else if (ef < 8'd102) begin
      r = {x[31], 15'd0};
    end else if (ef <= 8'd112) begin
      sh  = 5'(8'd126 - ef);
      hm  = mf >> sh;
      rem = mf & ((24'd1 << sh) - 24'd1);
      mid = 24'd1 << (sh - 5'd1);
      up  = (rem > mid) || ((rem == mid) && hm[0]);
      hm  = hm + {23'd0, up};
      r   = {x[31], hm[14:0]};
    end else if (ef >= 8'd143) begin
      r = {x[31], 15'h7c00};
    end else begin
      up = (m[12:0] > 13'h1000) || ((m[12:0] == 13'h1000) && m[13]);
      hn = {1'b0, m[22:13]} + {10'd0, up};
      if (hn[10]) begin
        if (ef == 8'd142) r = {x[31], 15'h7c00};
        else r = {x[31], 5'(ef - 8'd111), 10'd0};
      end else begin
        r = {x[31], 5'(ef - 8'd112), hn[9:0]};
      end
    end
    return r;
  endfunction
endpackage

// ----- design/ffc_core.sv -----
`timescale 1ns / 1ps
module ffc_core import ffc_pkg::*; (
  input  mode_t       mode,
  input  logic [31:0] operand,
  output logic [31:0] result_value
);
  // Select the conversion for the current mode.
  always_comb begin
    unique case (mode)
      MODE_BF16_TO_F32: result_value = {operand[15:0], 16'd0};
      MODE_F16_TO_F32:  result_value = f16_to_f32(operand[15:0]);
      MODE_F32_TO_BF16: result_value = {16'd0, f32_to_bf16(operand)};
      default:          result_value = {16'd0, f32_to_f16(operand)};
    endcase
  end
endmodule

// ----- design/float_format_converter.sv -----
`timescale 1ns / 1ps
// An accepted input word is held in the input register and then in the result
// register, which it enters when the pipeline next advances.
// Throughput: one word per cycle; the input register and result register
// both advance whenever the result register is empty or being taken.
// Reset: synchronous, active high; clears valid flags and sets the mode to
// bf16 to f32.
`include "assert_macros.svh"
module float_format_converter import ffc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);
  mode_t       mode;
  logic        s1_valid;
  in_word_t    s1_word;
  logic [31:0] conv;
  logic        advance;

  // The pipeline moves when the result register is free or being taken.
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_BF16_TO_F32;
    end else if (cfg_we) begin
      mode <= mode_t'(cfg_wdata);
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_word <= in_data;
    end
  end

  ffc_core u_core (
    .mode         (mode),
    .operand      (s1_word.operand),
    .result_value (conv)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.result_value <= conv;
      out_data.end_of_run   <= s1_word.last_element;
    end
  end

  // A stalled result word holds its value.
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  // A stage word moves into the result register when the pipe advances.
  `ASSERT_NEXT(a_move, clk, rst, s1_valid && advance, out_valid)
endmodule

// ----- sim/ffc_checker.sv -----
`timescale 1ns / 1ps
module ffc_checker import ffc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        fail_count,
  output int        pending
);
  mode_t     cur_mode;
  out_word_t expected_words[$];

  // Widen a binary16 pattern to binary32.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  e;
    logic [9:0]  m;
    int          ex;
    sgn = {h[15], 31'd0};
    e   = h[14:10];
    m   = h[9:0];
    if (e == 5'd0) begin
      if (m == 10'd0) return sgn;
      ex = 1;
      while (!m[9]) begin
        m = m << 1;
        ex--;
      end
      // One more shift drops the leading one.
      ex--;
      m = m << 1;
      return sgn | (32'(ex + 112) << 23) | ({22'd0, m} << 13);
    end
    if (e == 5'd31) return sgn | 32'h7f800000 | ({22'd0, m} << 13);
    return sgn | (32'(e + 112) << 23) | ({22'd0, m} << 13);
  endfunction

  // Narrow binary32 to bfloat16 by adding a round-to-nearest-even bias.
  function automatic logic [15:0] narrow_brain(input logic [31:0] x);
    logic [31:0] s;
    s = x + 32'h7fff + {31'd0, x[16]};
    return s[31:16];
  endfunction

  // Narrow binary32 to binary16 with rounding, subnormals and overflow.
  function automatic logic [15:0] narrow_half(input logic [31:0] x);
    logic [15:0] sgn;
    int          ex;
    logic [31:0] m;
    logic [31:0] hm;
    logic [31:0] rem;
    logic [31:0] mid;
    logic [31:0] nan;
    int          sh;
    sgn = {x[31], 15'd0};
    ex  = int'(x[30:23]) - 112;
    m   = {9'd0, x[22:0]};
    if (x[30:23] == 8'hff) begin
      if (m == 0) return sgn | 16'h7c00;
      nan = {16'd0, sgn} | 32'h7c00 | (m >> 13);
      if ((nan & 32'h3ff) == 0) nan |= 1;
      return nan[15:0];
    end
    if (ex <= 0) begin
      if (ex < -10) return sgn;
      m  = m | 32'h800000;
      sh = 14 - ex;
      hm = m >> sh;
      rem = m & ((32'd1 << sh) - 1);
      mid = 32'd1 << (sh - 1);
      if (rem > mid || (rem == mid && hm[0])) hm++;
      return sgn | hm[15:0];
    end
    if (ex >= 31) return sgn | 16'h7c00;
    hm  = m >> 13;
    rem = m & 32'h1fff;
    if (rem > 32'h1000 || (rem == 32'h1000 && hm[0])) begin
      hm++;
      if (hm == 32'h400) begin
        hm = 0;
        ex++;
        if (ex >= 31) return sgn | 16'h7c00;
      end
    end
    return sgn | 16'(ex << 10) | hm[15:0];
  endfunction

  function automatic logic [31:0] convert_word(input mode_t md, input logic [31:0] op);
    case (md)
      MODE_BF16_TO_F32: return {op[15:0], 16'd0};
      MODE_F16_TO_F32:  return widen_half(op[15:0]);
      MODE_F32_TO_BF16: return {16'd0, narrow_brain(op)};
      default:          return {16'd0, narrow_half(op)};
    endcase
  endfunction

  assign pending = expected_words.size();

  // Track the mode, predict each accepted word and compare each result.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      cur_mode   <= MODE_BF16_TO_F32;
      fail_count <= 0;
      expected_words.delete();
    end else begin
      if (cfg_we) cur_mode <= mode_t'(cfg_wdata);
      if (in_valid && in_ready) begin
        exp_w.result_value = convert_word(cur_mode, in_data.operand);
        exp_w.end_of_run   = in_data.last_element;
        expected_words.push_back(exp_w);
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.result_value !== out_data.result_value ||
              exp_w.end_of_run !== out_data.end_of_run) begin
            if (fail_count < 10)
              $display("mismatch: expected %h/%b, got %h/%b", exp_w.result_value,
                       exp_w.end_of_run, out_data.result_value, out_data.end_of_run);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- sim/tb_float_format_converter.sv -----
`timescale 1ns / 1ps
module tb_float_format_converter import ffc_pkg::*;;
  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  int        fail_count;
  int        pending;
  bit        calm = 1'b0;

  float_format_converter dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  ffc_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver stalls in random bursts, none once the run turns calm.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
      end else begin
        n = $urandom_range(1, 7);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Pick operands that reach the interesting exponent ranges.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v[30:23] = 8'd102 + 8'($urandom_range(0, 12));
      1: v[30:23] = 8'd140 + 8'($urandom_range(0, 4));
      2: v[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      3: v[12:0]  = $urandom_range(0, 1) ? 13'h1000 : 13'h0fff;
      default: ;
    endcase
    return v;
  endfunction

  // Offer one word and hold it until taken, with an optional gap first.
  task automatic send_word(input logic [31:0] op, input logic last);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operand: op, last_element: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Wait for the pipeline to drain, then write the mode.
  task automatic set_mode(input mode_t md);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= md;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  localparam logic [31:0] EDGE_OPS [20] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h0000_8000, 32'h0000_0001, 32'h0000_03ff,
    32'h0000_7c00, 32'h0000_7e00, 32'h0000_fc01, 32'h7f80_0000, 32'hff80_0000,
    32'h7fc0_0000, 32'h7f80_0001, 32'h7fff_ffff, 32'h477f_f000, 32'h477f_e000,
    32'h3380_0000, 32'h3300_0001, 32'h387f_f000, 32'h0000_0001, 32'h3f80_9000
  };

  initial begin
    mode_t modes [4] = '{MODE_F32_TO_F16, MODE_F16_TO_F32, MODE_F32_TO_BF16,
                        MODE_BF16_TO_F32};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed edge values under the reset mode and then under each of the four modes.
    for (int k = 0; k < 5; k++) begin
      if (k > 0) set_mode(modes[k - 1]);
      for (int i = 0; i < 5; i++) send_word(EDGE_OPS[k * 4 + i - (k == 4 ? 5 : 0)], i == 4);
    end
    // Random phases over all modes.
    for (int p = 0; p < 8; p++) begin
      set_mode(p < 4 ? modes[p] : mode_t'($urandom_range(0, 3)));
      if (p == 6) calm = 1'b1;
      for (int i = 0; i < 250; i++)
        send_word(pick_operand(), $urandom_range(0, 1));
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[float_format_converter] OK");
    end else begin
      $display("[float_format_converter] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[float_format_converter] ERROR");
    $finish;
  end
endmodule

// ----- float_format_converter.f -----
+incdir+design
design/ffc_pkg.sv
design/ffc_core.sv
design/float_format_converter.sv
sim/ffc_checker.sv
sim/tb_float_format_converter.sv
